// ===== rtl/core/csw_pkg.sv =====
`default_nettype none

package csw_pkg;

  // Fixed sizes of the semaphore.
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int WCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int TID_W       = 8;
  localparam int COUNT_W     = 16;
  localparam int VALUE_W     = 17;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 3;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [COUNT_W-1:0]    COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [QPTR_W-1:0]     QPTR_LAST  = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [WCNT_W-1:0]     WCNT_FULL  = WCNT_W'(QUEUE_DEPTH);
  localparam logic [APB_ADDR_W-1:0] ADDR_INIT_COUNT = '0;

  // Request codes.
  localparam logic [ACTION_W-1:0] ACT_DOWN  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_UP    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_ACQUIRED = 3'd0;
  localparam logic [STATUS_W-1:0] STS_BLOCKED  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_RELEASED = 3'd2;
  localparam logic [STATUS_W-1:0] STS_VALUE    = 3'd3;
  localparam logic [STATUS_W-1:0] STS_ERROR    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // capture the request and read the queue head
    logic exec;   // apply the request and load the result register
  } dp_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic [WCNT_W-1:0] wait_cnt;
    logic              count_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/csw_ctrl.sv =====
`default_nettype none

// Sequences one item at a time: capture, execute, present the result.
module csw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output csw_pkg::dp_cmd_t      cmd
);

  csw_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.take  = 1'b0;
    cmd.exec  = 1'b0;
    case (state_r)
      csw_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = csw_pkg::ST_EXEC;
        end
      end
      csw_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = csw_pkg::ST_DONE;
      end
      csw_pkg::ST_DONE: begin
        if (!out_stall) begin
          state_nxt = csw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != csw_pkg::ST_IDLE);
  assign out_valid = (state_r == csw_pkg::ST_DONE);

endmodule

`default_nettype wire

// ===== rtl/core/csw_dp.sv =====
`default_nettype none

// Count, wait queue and result register.
module csw_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire csw_pkg::dp_cmd_t              cmd,
  output csw_pkg::dp_sts_t                   sts,
  input  wire logic [csw_pkg::ACTION_W-1:0]  in_action,
  input  wire logic [csw_pkg::TID_W-1:0]     in_thread_id,
  input  wire logic                          cfg_we,
  input  wire logic [csw_pkg::COUNT_W-1:0]   cfg_data,
  output logic [csw_pkg::COUNT_W-1:0]        init_count,
  output logic [csw_pkg::STATUS_W-1:0]       res_status,
  output logic                               res_woken_valid,
  output logic [csw_pkg::TID_W-1:0]          res_woken_thread,
  output logic signed [csw_pkg::VALUE_W-1:0] res_value
);

  logic [csw_pkg::TID_W-1:0]    mem [csw_pkg::QUEUE_DEPTH];

  logic [csw_pkg::COUNT_W-1:0]  init_r;
  logic [csw_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [csw_pkg::QPTR_W-1:0]   head_r, head_nxt;
  logic [csw_pkg::QPTR_W-1:0]   tail_r, tail_nxt;
  logic [csw_pkg::WCNT_W-1:0]   wcnt_r, wcnt_nxt;
  logic [csw_pkg::ACTION_W-1:0] act_r;
  logic [csw_pkg::TID_W-1:0]    tid_r;
  logic [csw_pkg::TID_W-1:0]    head_data_r;
  logic                         push;

  logic [csw_pkg::STATUS_W-1:0]       status_nxt;
  logic                               wvalid_nxt;
  logic [csw_pkg::TID_W-1:0]          wtid_nxt;
  logic signed [csw_pkg::VALUE_W-1:0] value_nxt;

  always_comb begin
    count_nxt  = count_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    wcnt_nxt   = wcnt_r;
    push       = 1'b0;
    status_nxt = csw_pkg::STS_ERROR;
    wvalid_nxt = 1'b0;
    wtid_nxt   = '0;
    value_nxt  = '0;
    case (act_r)
      csw_pkg::ACT_DOWN: begin
        if (count_r != '0) begin
          count_nxt  = count_r - 1'b1;
          status_nxt = csw_pkg::STS_ACQUIRED;
        end else if (wcnt_r < csw_pkg::WCNT_FULL) begin
          push       = 1'b1;
          tail_nxt   = (tail_r == csw_pkg::QPTR_LAST) ? '0 : tail_r + 1'b1;
          wcnt_nxt   = wcnt_r + 1'b1;
          status_nxt = csw_pkg::STS_BLOCKED;
        end
      end
      csw_pkg::ACT_UP: begin
        if (wcnt_r != '0) begin
          wtid_nxt   = head_data_r;
          wvalid_nxt = 1'b1;
          head_nxt   = (head_r == csw_pkg::QPTR_LAST) ? '0 : head_r + 1'b1;
          wcnt_nxt   = wcnt_r - 1'b1;
          status_nxt = csw_pkg::STS_RELEASED;
        end else if (count_r != csw_pkg::COUNT_MAX) begin
          count_nxt  = count_r + 1'b1;
          status_nxt = csw_pkg::STS_RELEASED;
        end
      end
      csw_pkg::ACT_QUERY: begin
        if (count_r != '0) begin
          value_nxt = signed'(csw_pkg::VALUE_W'(count_r));
        end else begin
          value_nxt = signed'(csw_pkg::VALUE_W'(0) - csw_pkg::VALUE_W'(wcnt_r));
        end
        status_nxt = csw_pkg::STS_VALUE;
      end
      default: begin
        status_nxt = csw_pkg::STS_ERROR;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r  <= '0;
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      wcnt_r  <= '0;
    end else if (cfg_we) begin
      init_r  <= cfg_data;
      count_r <= cfg_data;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  // Request capture, queue storage and result register.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act_r       <= in_action;
      tid_r       <= in_thread_id;
      head_data_r <= mem[head_r];
    end
    if (cmd.exec && push) begin
      mem[tail_r] <= tid_r;
    end
    if (cmd.exec) begin
      res_status       <= status_nxt;
      res_woken_valid  <= wvalid_nxt;
      res_woken_thread <= wtid_nxt;
      res_value        <= value_nxt;
    end
  end

  assign init_count     = init_r;
  assign sts.wait_cnt   = wcnt_r;
  assign sts.count_zero = (count_r == '0);

endmodule

`default_nettype wire

// ===== rtl/core/counting_semaphore_waitq_top.sv =====
`default_nettype none

// Counting semaphore with a FIFO queue of up to 16 waiting thread ids. Each
// item is a down, an up or a query tagged with an 8-bit thread id, and every
// item gives exactly one result item. A down takes a unit when the count is
// nonzero and otherwise queues the thread and reports blocked; an up hands
// its unit straight to the oldest waiter (reporting its id) or, with no
// waiters, increments the count; a query reports the count, or minus the
// number of waiters when the count is zero. A full queue, a count overflow
// and the unused action code report an error and change nothing. Writing
// initial_count (byte address 0) stores it and loads the count at once; the
// queue is untouched. Reset clears the register, so the count starts at 0.
// One item is handled at a time: it is captured and the queue head is read
// from the queue memory, then it is applied, then the result is presented.
// A stalled result holds the next item off until it has been taken.
module counting_semaphore_waitq_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // request channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [csw_pkg::ACTION_W-1:0]         in_action,
  input  wire logic [csw_pkg::TID_W-1:0]            in_thread_id,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [csw_pkg::STATUS_W-1:0]              out_status,
  output logic                                      out_woken_valid,
  output logic [csw_pkg::TID_W-1:0]                 out_woken_thread,
  output logic signed [csw_pkg::VALUE_W-1:0]        out_value,
  // configuration port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [csw_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [csw_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [csw_pkg::APB_DATA_W-1:0]            prdata,
  output logic                                      pready
);

  csw_pkg::dp_cmd_t cmd;
  csw_pkg::dp_sts_t sts;

  logic                         cfg_we;
  logic [csw_pkg::COUNT_W-1:0]  init_count;

  // The port never inserts wait states. Only the one register is decoded;
  // writes elsewhere are ignored and reads there return zero.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == csw_pkg::ADDR_INIT_COUNT);
  assign prdata = (paddr == csw_pkg::ADDR_INIT_COUNT) ?
                  csw_pkg::APB_DATA_W'(init_count) : '0;

  // The controller decides when an item is taken and when its result is shown.
  csw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the count, the wait queue and the result register,
  // which stays put while the result is stalled.
  csw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_thread_id     (in_thread_id),
    .cfg_we           (cfg_we),
    .cfg_data         (pwdata[csw_pkg::COUNT_W-1:0]),
    .init_count       (init_count),
    .res_status       (out_status),
    .res_woken_valid  (out_woken_valid),
    .res_woken_thread (out_woken_thread),
    .res_value        (out_value)
  );

  // The number of waiters can never exceed the queue depth.
  a_wcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.wait_cnt <= csw_pkg::WCNT_FULL)
    else $error("waiter count beyond queue depth");

  // A down is only ever blocked when no unit was free, and a blocked down
  // leaves the count as it found it.
  a_blocked_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == csw_pkg::STS_BLOCKED) |-> sts.count_zero)
    else $error("down blocked while units are free");

  // No new item is taken while a result is on show.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("item accepted while a result is pending");

  // A woken thread is only ever reported for a release.
  a_woken_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_woken_valid |-> out_status == csw_pkg::STS_RELEASED)
    else $error("woken thread on a result that is not a release");

endmodule

`default_nettype wire
